// ===== hdl/mduh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mduh_pkg
// Types and constants shared by the multidimensional uniform histogram.
// ----------------------------------------------------------------------------
package mduh_pkg;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned BIN_W       = 5;
  localparam int unsigned NUM_W       = VALUE_W + BIN_W;
  localparam int unsigned STEP_W      = 3;
  localparam int unsigned FLAT_W      = 2 * BIN_W;
  localparam int unsigned CFG_AW      = 5;

  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  localparam logic MODE_READ = 1'b1;

  localparam logic [2:0] REG_DIMS  = 3'd0;
  localparam logic [2:0] REG_BINS0 = 3'd1;
  localparam logic [2:0] REG_LOW0  = 3'd2;
  localparam logic [2:0] REG_HIGH0 = 3'd3;
  localparam logic [2:0] REG_BINS1 = 3'd4;
  localparam logic [2:0] REG_LOW1  = 3'd5;
  localparam logic [2:0] REG_HIGH1 = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] sample_x;
    logic signed [VALUE_W-1:0] sample_y;
    logic [ADDR_W-1:0]         read_bin;
  } mduh_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  flat_bin;
    logic [COUNT_W-1:0] bin_count;
  } mduh_out_t;

  typedef struct packed {
    logic             done;
    logic             in_range;
    logic [BIN_W-1:0] bin;
  } mduh_lane_res_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } mduh_wr_t;

endpackage

// ===== hdl/mduh_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mduh_lane
// One dimension: range check and bin number by restoring division, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mduh_lane import mduh_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic signed [VALUE_W-1:0] low_i,
  input  logic signed [VALUE_W-1:0] high_i,
  input  logic [BIN_W-1:0]          nbins_i,
  output mduh_lane_res_t            res_o
);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [VALUE_W-1:0] span_q, span_d;
  logic [BIN_W-1:0]  quo_q, quo_d;
  logic              rng_q, rng_d;

  logic signed [VALUE_W:0] off;
  logic signed [VALUE_W:0] spn;
  logic [NUM_W-1:0]        trial;

  always_comb begin
    off   = {value_i[VALUE_W-1], value_i} - {low_i[VALUE_W-1], low_i};
    spn   = {high_i[VALUE_W-1], high_i} - {low_i[VALUE_W-1], low_i};
    trial = NUM_W'(span_q) << cnt_q;

    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    span_d = span_q;
    quo_d  = quo_q;
    rng_d  = rng_q;

    if (go_i) begin
      run_d  = 1'b1;
      cnt_d  = STEP_W'(BIN_W - 1);
      rem_d  = NUM_W'(off[VALUE_W-1:0]) * NUM_W'(nbins_i);
      span_d = spn[VALUE_W-1:0];
      quo_d  = '0;
      rng_d  = !off[VALUE_W] && (value_i < high_i);
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_d        = rem_q - trial;
        quo_d[cnt_q] = 1'b1;
      end
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    quo_q  <= quo_d;
    rng_q  <= rng_d;
  end

  assign res_o.done     = done_q;
  assign res_o.in_range = rng_q;
  assign res_o.bin      = quo_q;

endmodule

// ===== hdl/mduh_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mduh_store
// Bin counter memory with registered read and per-entry valid bits; an
// entry never written reads as zero.
// ----------------------------------------------------------------------------
module mduh_store import mduh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  input  mduh_wr_t           wr_i,
  output logic [COUNT_W-1:0] rd_data_o
);

  logic [COUNT_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [COUNT_W-1:0]     data_q;
  logic                   hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? data_q : '0;

endmodule

// ===== hdl/multidim_uniform_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multidim_uniform_histogram
// Up to two dimensional histogram over uniform bins with saturating counts.
// Count item: 5-step bin division per lane, then merge, store read and
//   update; busy holds off the next start until the item is through.
// Out-of-range item: range status without store access. Read item: store read.
// Reset clears configuration to defaults and all counts to zero at once.
// Results cannot be stalled; one result per item.
// ----------------------------------------------------------------------------
module multidim_uniform_histogram import mduh_pkg::*; #(
  parameter int unsigned MAX_BINS_PER_DIM = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mduh_in_t          item_i,
  output logic              done_o,
  output mduh_out_t         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_ACC  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]               dims_q;
  logic [BIN_W-1:0]         bins0_q, bins1_q;
  logic signed [VALUE_W-1:0] low0_q, high0_q, low1_q, high1_q;

  logic                     mode_q, mode_d;
  logic [ADDR_W-1:0]        flat_q, flat_d;
  logic                     oor_q, oor_d;
  logic                     done_q, done_d;
  mduh_out_t                res_q, res_d;

  logic                     accept;
  logic                     lane_go;
  logic [BIN_W-1:0]         nb0, nb1;
  logic                     two;
  logic [FLAT_W-1:0]        flat_w;
  logic                     rd_en;
  logic [COUNT_W-1:0]       rd_data;
  logic [COUNT_W-1:0]       count_inc;
  mduh_wr_t                 wr;
  mduh_lane_res_t           lane0, lane1;
  logic [2:0]               reg_idx;

  function automatic logic [BIN_W-1:0] clamp_bins(input logic [BIN_W-1:0] b);
    logic [BIN_W-1:0] r;
    r = b;
    if (b == '0) begin
      r = BIN_W'(1);
    end else if (32'(b) > MAX_BINS_PER_DIM) begin
      r = BIN_W'(MAX_BINS_PER_DIM);
    end
    return r;
  endfunction

  assign nb0     = clamp_bins(bins0_q);
  assign nb1     = clamp_bins(bins1_q);
  assign two     = dims_q[1];
  assign accept  = start && !busy;
  assign lane_go = accept && (item_i.mode != MODE_READ);
  assign busy    = (state_q != S_IDLE);
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  mduh_lane u_lane0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (lane_go),
    .value_i (item_i.sample_x),
    .low_i   (low0_q),
    .high_i  (high0_q),
    .nbins_i (nb0),
    .res_o   (lane0)
  );

  mduh_lane u_lane1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (lane_go),
    .value_i (item_i.sample_y),
    .low_i   (low1_q),
    .high_i  (high1_q),
    .nbins_i (nb1),
    .res_o   (lane1)
  );

  mduh_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (flat_q),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  // merge: mixed-radix flat index, dimension zero least significant
  assign flat_w = FLAT_W'(lane0.bin) +
                  (two ? FLAT_W'(lane1.bin) * FLAT_W'(nb0) : FLAT_W'(0));

  assign count_inc = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    flat_d  = flat_q;
    oor_d   = oor_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_en   = 1'b0;
    wr.en   = 1'b0;
    wr.addr = flat_q;
    wr.data = count_inc;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = item_i.mode;
          if (item_i.mode == MODE_READ) begin
            flat_d  = item_i.read_bin;
            oor_d   = 1'b0;
            state_d = S_ACC;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (lane0.done) begin
          oor_d   = !lane0.in_range || (two && !lane1.in_range) ||
                    (32'(flat_w) >= STORE_DEPTH);
          flat_d  = flat_w[ADDR_W-1:0];
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (oor_q) begin
          done_d          = 1'b1;
          res_d.status    = ST_RANGE;
          res_d.flat_bin  = '0;
          res_d.bin_count = '0;
          state_d         = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        done_d         = 1'b1;
        res_d.flat_bin = flat_q;
        if (mode_q == MODE_READ) begin
          res_d.status    = ST_READ;
          res_d.bin_count = rd_data;
        end else begin
          wr.en           = 1'b1;
          res_d.status    = ST_COUNTED;
          res_d.bin_count = count_inc;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      mode_q  <= 1'b0;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      mode_q  <= mode_d;
      oor_q   <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flat_q <= flat_d;
    res_q  <= res_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= 2'd2;
      bins0_q <= BIN_W'(16);
      low0_q  <= '0;
      high0_q <= 32'sd65536;
      bins1_q <= BIN_W'(16);
      low1_q  <= '0;
      high1_q <= 32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DIMS:  dims_q  <= pwdata[1:0];
        REG_BINS0: bins0_q <= pwdata[BIN_W-1:0];
        REG_LOW0:  low0_q  <= pwdata;
        REG_HIGH0: high0_q <= pwdata;
        REG_BINS1: bins1_q <= pwdata[BIN_W-1:0];
        REG_LOW1:  low1_q  <= pwdata;
        REG_HIGH1: high1_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIMS:  prdata = 32'(dims_q);
      REG_BINS0: prdata = 32'(bins0_q);
      REG_LOW0:  prdata = low0_q;
      REG_HIGH0: prdata = high0_q;
      REG_BINS1: prdata = 32'(bins1_q);
      REG_LOW1:  prdata = low1_q;
      REG_HIGH1: prdata = high1_q;
      default:   prdata = '0;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
